// ----- hdl/owe_pkg.sv -----
// Shared types and constants for the override window extractor.
package owe_pkg;

    localparam int TS_W        = 63;
    localparam int MODE_W      = 8;
    localparam int MARGIN_W    = 40;
    localparam int INDEX_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    localparam logic [TS_W-1:0]    TS_MAX    = {TS_W{1'b1}};
    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    localparam logic [MODE_W-1:0] OVERRIDE_MODE_RST = 8'd4;
    localparam logic [MODE_W-1:0] INITIAL_MODE_RST  = 8'd1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OVERRIDE_MODE = 3'd0,
        CFG_INITIAL_MODE  = 3'd1,
        CFG_FILTER_ENABLE = 3'd2,
        CFG_MIN_DURATION  = 3'd3,
        CFG_PRE_MARGIN    = 3'd4,
        CFG_POST_MARGIN   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic              command;
        logic [MODE_W-1:0] mode;
        logic [TS_W-1:0]   timestamp_ns;
    } item_t;

    typedef struct packed {
        logic [TS_W-1:0]    raw_start_ns;
        logic [TS_W-1:0]    raw_end_ns;
        logic [TS_W-1:0]    window_start_ns;
        logic [TS_W-1:0]    window_end_ns;
        logic [INDEX_W-1:0] event_index;
        logic               last;
    } result_t;

    // Work handed from the front to the back: a kept raw interval and/or a flush
    typedef struct packed {
        logic            close;
        logic            flush;
        logic [TS_W-1:0] span_start;
        logic [TS_W-1:0] span_end;
        logic [TS_W-1:0] win_start;
        logic [TS_W-1:0] win_end;
    } entry_t;

endpackage

// ----- hdl/owe_front.sv -----
// Front end: configuration registers, mode tracking and interval classification.
module owe_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [owe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  owe_pkg::item_t                item,
    output logic                          push_valid,
    input  logic                          push_ready,
    output owe_pkg::entry_t               push_entry
);
    import owe_pkg::*;

    logic [MODE_W-1:0]   override_mode_reg;
    logic [MODE_W-1:0]   initial_mode_reg;
    logic                filter_enable_reg;
    logic [MARGIN_W-1:0] min_duration_reg;
    logic [MARGIN_W-1:0] pre_margin_reg;
    logic [MARGIN_W-1:0] post_margin_reg;

    logic [MODE_W-1:0] prev_mode_reg;
    logic              open_reg;
    logic [TS_W-1:0]   start_reg;

    logic              was_override;
    logic              now_override;
    logic              is_flush;
    logic              sample_close;
    logic              accept;
    logic              keep;
    logic [TS_W:0]     duration;
    logic [TS_W:0]     end_sum;
    logic [TS_W-1:0]   win_start_calc;
    logic [TS_W-1:0]   win_end_calc;

    // Classify the incoming beat
    always_comb
    begin
        was_override = (prev_mode_reg == override_mode_reg);
        now_override = (item.mode == override_mode_reg);
        is_flush     = (item.command == CMD_FLUSH);
        sample_close = !is_flush && was_override && !now_override && open_reg;
        accept       = item_valid && item_ready;

        // Window bounds from the held start time, with the margins in force at close
        if (start_reg > TS_W'(pre_margin_reg))
            win_start_calc = start_reg - TS_W'(pre_margin_reg);
        else
            win_start_calc = '0;
        end_sum      = {1'b0, start_reg} + (TS_W+1)'(post_margin_reg);
        win_end_calc = end_sum[TS_W] ? TS_MAX : end_sum[TS_W-1:0];

        // Drop short or reversed intervals when filtering
        duration = {1'b0, item.timestamp_ns} - {1'b0, start_reg};
        keep     = !filter_enable_reg ||
                   (!duration[TS_W] && (duration[TS_W-1:0] >= TS_W'(min_duration_reg)));

        push_valid            = item_valid && (is_flush || (sample_close && keep));
        push_entry.close      = is_flush ? (open_reg && keep) : 1'b1;
        push_entry.flush      = is_flush;
        push_entry.span_start = start_reg;
        push_entry.span_end   = item.timestamp_ns;
        push_entry.win_start  = win_start_calc;
        push_entry.win_end    = win_end_calc;
    end

    assign item_ready = push_ready;

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            override_mode_reg <= OVERRIDE_MODE_RST;
            initial_mode_reg  <= INITIAL_MODE_RST;
            filter_enable_reg <= 1'b0;
            min_duration_reg  <= '0;
            pre_margin_reg    <= '0;
            post_margin_reg   <= '0;
            prev_mode_reg     <= INITIAL_MODE_RST;
            open_reg          <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (is_flush)
                begin
                    open_reg      <= 1'b0;
                    prev_mode_reg <= initial_mode_reg;
                end
                else
                begin
                    if (!was_override && now_override)
                        open_reg <= 1'b1;
                    else if (sample_close)
                        open_reg <= 1'b0;
                    prev_mode_reg <= item.mode;
                end
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_OVERRIDE_MODE: override_mode_reg <= cfg_data[MODE_W-1:0];
                    CFG_INITIAL_MODE:
                    begin
                        initial_mode_reg <= cfg_data[MODE_W-1:0];
                        prev_mode_reg    <= cfg_data[MODE_W-1:0];
                    end
                    CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                    CFG_MIN_DURATION:  min_duration_reg  <= cfg_data[MARGIN_W-1:0];
                    CFG_PRE_MARGIN:    pre_margin_reg    <= cfg_data[MARGIN_W-1:0];
                    CFG_POST_MARGIN:   post_margin_reg   <= cfg_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Capture the start time when an override opens
    always_ff @(posedge clk)
    begin
        if (accept && !is_flush && !was_override && now_override)
        begin
            start_reg <= item.timestamp_ns;
        end
    end

endmodule

// ----- hdl/owe_queue.sv -----
// Small flip-flop queue between front and back.
module owe_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  owe_pkg::entry_t push_entry,
    output logic            head_valid,
    input  logic            pop,
    output owe_pkg::entry_t head
);
    import owe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- hdl/owe_back.sv -----
// Back end: merges windows into the pending event and emits result beats.
module owe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  owe_pkg::entry_t  head,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output owe_pkg::result_t result
);
    import owe_pkg::*;

    typedef enum logic [1:0] {
        PH_CLOSE = 2'b01,
        PH_FLUSH = 2'b10
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [TS_W-1:0]    pend_rs_reg, pend_rs_next;
    logic [TS_W-1:0]    pend_re_reg, pend_re_next;
    logic [TS_W-1:0]    pend_ws_reg, pend_ws_next;
    logic [TS_W-1:0]    pend_we_reg, pend_we_next;
    logic [INDEX_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               can_out;
    logic               overlap;
    logic               do_flush;
    logic [INDEX_W-1:0] count_inc;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        pend_valid_next = pend_valid_reg;
        pend_rs_next    = pend_rs_reg;
        pend_re_next    = pend_re_reg;
        pend_ws_next    = pend_ws_reg;
        pend_we_next    = pend_we_reg;
        count_next      = count_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        pop             = 1'b0;
        do_flush        = 1'b0;

        can_out   = !out_valid_reg || result_ready;
        overlap   = pend_valid_reg && (pend_ws_reg <= head.win_end) &&
                    (head.win_start <= pend_we_reg);
        count_inc = (count_reg == INDEX_MAX) ? count_reg : count_reg + 1'b1;

        // Load the beat from the pending event only once the output slot frees
        if (can_out)
        begin
            out_next.raw_start_ns    = pend_rs_reg;
            out_next.raw_end_ns      = pend_re_reg;
            out_next.window_start_ns = pend_ws_reg;
            out_next.window_end_ns   = pend_we_reg;
            out_next.event_index     = count_reg;
            out_next.last            = 1'b1;
        end

        if (head_valid && can_out)
        begin
            case (phase_reg)
                PH_CLOSE:
                begin
                    if (head.close)
                    begin
                        if (overlap)
                        begin
                            // Merge into the pending event
                            if (head.win_start < pend_ws_reg) pend_ws_next = head.win_start;
                            if (head.win_end > pend_we_reg)   pend_we_next = head.win_end;
                            if (head.span_start < pend_rs_reg) pend_rs_next = head.span_start;
                            if (head.span_end > pend_re_reg)   pend_re_next = head.span_end;
                        end
                        else
                        begin
                            // Emit the old event and start a new one
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_next.last  = !head.flush;
                                count_next     = count_inc;
                            end
                            pend_valid_next = 1'b1;
                            pend_rs_next    = head.span_start;
                            pend_re_next    = head.span_end;
                            pend_ws_next    = head.win_start;
                            pend_we_next    = head.win_end;
                        end
                        if (head.flush)
                            phase_next = PH_FLUSH;
                        else
                            pop = 1'b1;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                    end
                end
                PH_FLUSH:
                begin
                    do_flush = 1'b1;
                end
                default:
                begin
                    phase_next = PH_CLOSE;
                end
            endcase
        end

        // Drain the pending event and start a new log
        if (do_flush)
        begin
            if (pend_valid_reg)
                out_valid_next = 1'b1;
            pend_valid_next = 1'b0;
            count_next      = '0;
            phase_next      = PH_CLOSE;
            pop             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CLOSE;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the event and result payloads
    always_ff @(posedge clk)
    begin
        pend_rs_reg <= pend_rs_next;
        pend_re_reg <= pend_re_next;
        pend_ws_reg <= pend_ws_next;
        pend_we_reg <= pend_we_next;
        out_reg     <= out_next;
    end

endmodule

// ----- hdl/override_window_extractor_core.sv -----
// Top level: override window extractor, front, queue and back joined.
// Path: an accepted input beat pushes an entry into the queue; the back end takes it
// from the queue head, behind earlier work, and registers the result beat it causes.
// Throughput: one input beat per cycle while the queue has room; a flush that closes
// a kept override takes a close step and a flush step, one per result it may emit.
// Reset: asynchronous, active low; clears control state and returns every
// configuration register to its reset value. No clearing pass is needed.
module override_window_extractor_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [owe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  owe_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output owe_pkg::result_t                result
);
    import owe_pkg::*;

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   head_valid;
    logic   pop;
    entry_t head;

    assign cfg_ready = 1'b1;

    owe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    owe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head       (head)
    );

    owe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the override window extractor: random mode-sample streams scored beat by beat.
module tb_top;
    import owe_pkg::*;

    localparam int                  SETTLE_CYCLES = 8;
    localparam int                  LIMIT_CYCLES  = 1000000;
    localparam int                  PHASES        = 10;
    localparam int                  PHASE_ITEMS   = 130;
    localparam int                  REPORT_CAP    = 50;
    localparam logic [MARGIN_W-1:0] MARGIN_MAX    = {MARGIN_W{1'b1}};

    // Tracks open overrides and the pending merged window; holds the event beats still due
    class event_ledger;
        logic [MODE_W-1:0]   ovr_code;
        logic [MODE_W-1:0]   init_code;
        logic                filt_on;
        logic [MARGIN_W-1:0] min_len;
        logic [MARGIN_W-1:0] pre_ns;
        logic [MARGIN_W-1:0] post_ns;

        logic [MODE_W-1:0]   prev_mode;
        logic                in_ovr;
        logic [TS_W-1:0]     ovr_start;
        logic                have_evt;
        logic [TS_W-1:0]     ev_raw_s;
        logic [TS_W-1:0]     ev_raw_e;
        logic [TS_W-1:0]     ev_win_s;
        logic [TS_W-1:0]     ev_win_e;
        logic [INDEX_W-1:0]  evt_count;

        result_t             due_events[$];
        int                  mismatches;

        function new();
            ovr_code   = OVERRIDE_MODE_RST;
            init_code  = INITIAL_MODE_RST;
            filt_on    = 1'b0;
            min_len    = '0;
            pre_ns     = '0;
            post_ns    = '0;
            prev_mode  = INITIAL_MODE_RST;
            in_ovr     = 1'b0;
            ovr_start  = '0;
            have_evt   = 1'b0;
            ev_raw_s   = '0;
            ev_raw_e   = '0;
            ev_win_s   = '0;
            ev_win_e   = '0;
            evt_count  = '0;
            mismatches = 0;
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OVERRIDE_MODE: ovr_code = data[MODE_W-1:0];
                CFG_INITIAL_MODE:
                begin
                    init_code = data[MODE_W-1:0];
                    prev_mode = data[MODE_W-1:0];
                end
                CFG_FILTER_ENABLE: filt_on = data[0];
                CFG_MIN_DURATION:  min_len = data[MARGIN_W-1:0];
                CFG_PRE_MARGIN:    pre_ns  = data[MARGIN_W-1:0];
                CFG_POST_MARGIN:   post_ns = data[MARGIN_W-1:0];
                default:           ;
            endcase
        endfunction

        // Queue the pending event as a due beat and advance the saturating index
        function void emit_event();
            result_t r;
            r.raw_start_ns    = ev_raw_s;
            r.raw_end_ns      = ev_raw_e;
            r.window_start_ns = ev_win_s;
            r.window_end_ns   = ev_win_e;
            r.event_index     = evt_count;
            r.last            = 1'b0;
            due_events.insert(due_events.size(), r);
            if (evt_count != INDEX_MAX)
                evt_count++;
            have_evt = 1'b0;
        endfunction

        // Close a raw interval: filter it, widen it, then merge or start a new event
        function void close_span(input logic [TS_W-1:0] s, input logic [TS_W-1:0] e);
            logic [TS_W-1:0] ws;
            logic [TS_W:0]   we;
            if (filt_on && ((e < s) || ((e - s) < TS_W'(min_len))))
                return;
            ws = (s > TS_W'(pre_ns)) ? s - TS_W'(pre_ns) : '0;
            we = {1'b0, s} + (TS_W+1)'(post_ns);
            if (we > {1'b0, TS_MAX})
                we = {1'b0, TS_MAX};
            if (have_evt && ({1'b0, ev_win_s} <= we) && (ws <= ev_win_e)) begin
                if (ws < ev_win_s)
                    ev_win_s = ws;
                if (we[TS_W-1:0] > ev_win_e)
                    ev_win_e = we[TS_W-1:0];
                if (s < ev_raw_s)
                    ev_raw_s = s;
                if (e > ev_raw_e)
                    ev_raw_e = e;
                return;
            end
            if (have_evt)
                emit_event();
            have_evt = 1'b1;
            ev_raw_s = s;
            ev_raw_e = e;
            ev_win_s = ws;
            ev_win_e = we[TS_W-1:0];
        endfunction

        function void note_item(input item_t it);
            int      due_before;
            logic    was_ovr;
            logic    now_ovr;
            due_before = due_events.size();
            if (it.command == CMD_SAMPLE) begin
                was_ovr = (prev_mode == ovr_code);
                now_ovr = (it.mode == ovr_code);
                if (!was_ovr && now_ovr) begin
                    in_ovr    = 1'b1;
                    ovr_start = it.timestamp_ns;
                end
                else if (was_ovr && !now_ovr && in_ovr) begin
                    close_span(ovr_start, it.timestamp_ns);
                    in_ovr = 1'b0;
                end
                prev_mode = it.mode;
            end
            else begin
                // End of log: close, drain, then start a fresh log
                if (in_ovr)
                    close_span(ovr_start, it.timestamp_ns);
                if (have_evt)
                    emit_event();
                in_ovr    = 1'b0;
                ovr_start = '0;
                prev_mode = init_code;
                evt_count = '0;
            end
            // Mark the final beat caused by this input
            if (due_events.size() > due_before)
                due_events[due_events.size() - 1].last = 1'b1;
        endfunction

        task cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(input result_t got);
            result_t want;
            if (due_events.size() == 0) begin
                report("result beat with no event due");
                return;
            end
            want = due_events.pop_front();
            cmp_field("raw_start_ns", 64'(got.raw_start_ns), 64'(want.raw_start_ns));
            cmp_field("raw_end_ns", 64'(got.raw_end_ns), 64'(want.raw_end_ns));
            cmp_field("window_start_ns", 64'(got.window_start_ns), 64'(want.window_start_ns));
            cmp_field("window_end_ns", 64'(got.window_end_ns), 64'(want.window_end_ns));
            cmp_field("event_index", 64'(got.event_index), 64'(want.event_index));
            cmp_field("last", 64'(got.last), 64'(want.last));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_ready;
    item_t                  item;
    logic                   result_valid;
    logic                   result_ready;
    result_t                result;

    event_ledger            sb;
    bit                     calm;
    logic [TS_W-1:0]        cur_ts;
    logic [63:0]            span;

    override_window_extractor_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly short gaps, now and then a long one; none during calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the log clock, occasionally stepping back, saturating at the top
    function automatic logic [TS_W-1:0] step_ts();
        logic [63:0] d;
        logic [63:0] t;
        d = rand64() % (span + 64'd1);
        if ($urandom_range(0, 19) == 0) begin
            cur_ts = (64'(cur_ts) > d) ? cur_ts - TS_W'(d) : '0;
        end
        else begin
            t = 64'(cur_ts) + d;
            cur_ts = (t > 64'(TS_MAX)) ? TS_MAX : TS_W'(t);
        end
        return cur_ts;
    endfunction

    function automatic void pick_base();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            cur_ts = TS_W'($urandom_range(0, 5000));
        else if (r < 8)
            cur_ts = TS_MAX - TS_W'(rand64() % (span * 64'd4 + 64'd1));
        else
            cur_ts = TS_W'(rand64());
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return sb.ovr_code;
        if (r < 90)
            return sb.init_code;
        return MODE_W'($urandom);
    endfunction

    function automatic logic [MARGIN_W-1:0] pick_margin();
        if ($urandom_range(0, 4) != 0)
            return MARGIN_W'($urandom_range(0, 2000));
        return MARGIN_W'(rand64());
    endfunction

    // Present one input beat and hold it until accepted
    task automatic send_item(input item_t it);
        int gap;
        bit hit;
        gap = pick_gap();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        hit = 1'b0;
        while (!hit) begin
            @(negedge clk);
            hit = item_ready;
            @(posedge clk);
        end
        sb.note_item(it);
    endtask

    task automatic sample(input logic [MODE_W-1:0] m, input logic [TS_W-1:0] ts);
        item_t it;
        it.command      = CMD_SAMPLE;
        it.mode         = m;
        it.timestamp_ns = ts;
        send_item(it);
    endtask

    task automatic flush(input logic [TS_W-1:0] ts);
        item_t it;
        it.command      = CMD_FLUSH;
        it.mode         = MODE_W'($urandom);
        it.timestamp_ns = ts;
        send_item(it);
    endtask

    task automatic write_reg_beat(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        bit hit;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        hit = 1'b0;
        while (!hit) begin
            @(negedge clk);
            hit = cfg_ready;
            @(posedge clk);
        end
        sb.write_reg(idx, val);
    endtask

    // Drop valid, wait for every due beat, then let the pipeline drain
    task automatic settle();
        item_valid <= 1'b0;
        while (sb.due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [MODE_W-1:0] ovr, input logic [MODE_W-1:0] init,
                                 input logic filt, input logic [MARGIN_W-1:0] mn,
                                 input logic [MARGIN_W-1:0] pr, input logic [MARGIN_W-1:0] po);
        logic [MARGIN_W-1:0] widest;
        settle();
        // Narrow registers get junk in the unused upper bits
        write_reg_beat(CFG_OVERRIDE_MODE, {$urandom, ovr});
        write_reg_beat(CFG_INITIAL_MODE, {$urandom, init});
        write_reg_beat(CFG_FILTER_ENABLE, {$urandom, 7'($urandom), filt});
        write_reg_beat(CFG_MIN_DURATION, mn);
        write_reg_beat(CFG_PRE_MARGIN, pr);
        write_reg_beat(CFG_POST_MARGIN, po);
        // An index past the last register must change nothing
        write_reg_beat(CFG_INDEX_W'($urandom_range(int'(CFG_POST_MARGIN) + 1,
                                                   (1 << CFG_INDEX_W) - 1)),
                       CFG_DATA_W'(rand64()));
        cfg_valid <= 1'b0;
        // Scale time steps to the margins so that windows both merge and split
        widest = mn;
        if (pr > widest)
            widest = pr;
        if (po > widest)
            widest = po;
        span = 64'(widest) * 64'd2 + 64'd64;
    endtask

    task automatic run_phase(input int p);
        logic [MODE_W-1:0] code;
        logic [71:0]       raw;
        int                r;
        code = MODE_W'($urandom);
        case (p)
            0: apply_setting(8'd4, 8'd1, 1'b0, '0, '0, '0);
            1: apply_setting(code, MODE_W'($urandom), 1'b1, MARGIN_W'($urandom_range(0, 400)),
                             MARGIN_W'($urandom_range(0, 500)), MARGIN_W'($urandom_range(0, 500)));
            2: apply_setting(code, MODE_W'($urandom), 1'b0, MARGIN_MAX, MARGIN_MAX, MARGIN_MAX);
            3: apply_setting(code, code, 1'b1, '0, MARGIN_W'(1000), MARGIN_W'(1000));
            4: apply_setting(8'd0, 8'd255, 1'b1, MARGIN_MAX, '0, MARGIN_MAX);
            5: apply_setting(8'd255, 8'd0, 1'b0, MARGIN_W'(rand64()), MARGIN_W'(rand64()),
                             MARGIN_W'(rand64()));
            default: apply_setting(code, MODE_W'($urandom), 1'($urandom_range(0, 1)),
                                   pick_margin(), pick_margin(), pick_margin());
        endcase
        pick_base();
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            calm = (p % 2 == 1) && (n < 40);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                flush(step_ts());
                pick_base();
            end
            else if (r < 11) begin
                // Noise: any command, mode and time
                raw = {8'($urandom), rand64()};
                send_item(item_t'(raw));
            end
            else begin
                sample(pick_mode(), step_ts());
            end
        end
        calm = 1'b0;
    endtask

    // Stimulus and end of run
    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        calm       = 1'b0;
        cur_ts     = '0;
        span       = 64'd64;
        sb         = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register reset values: plain intervals, repeats, inclusive merge, flush cases
        sample(8'd4, TS_W'(100));
        sample(8'd4, TS_W'(150));
        sample(8'd1, TS_W'(200));
        sample(8'd4, TS_W'(300));
        sample(8'd255, TS_W'(400));
        sample(8'd4, TS_W'(300));
        sample(8'd0, TS_W'(350));
        flush(TS_W'(500));
        sample(8'd4, TS_W'(1000));
        sample(8'd2, TS_W'(50));
        sample(8'd4, TS_W'(2000));
        flush(TS_W'(3000));
        flush(TS_MAX);
        sample(8'd4, TS_MAX);
        sample(8'd1, '0);
        flush('0);

        // Extreme registers: window clamp and saturation, short and reversed drops
        apply_setting(8'd255, 8'd0, 1'b1, MARGIN_MAX, MARGIN_MAX, MARGIN_MAX);
        sample(8'd255, TS_W'(5));
        sample(8'd0, TS_W'(5) + TS_W'(MARGIN_MAX));
        sample(8'd255, TS_MAX - TS_W'(10));
        sample(8'd0, TS_MAX);
        sample(8'd255, TS_W'(1000));
        sample(8'd3, TS_W'(10));
        sample(8'd255, TS_MAX - (TS_W'(MARGIN_MAX) + TS_W'(1)));
        flush(TS_MAX);

        for (int p = 0; p < PHASES; p++)
            run_phase(p);
        flush(step_ts());

        settle();
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result back-pressure: random stalls between bursts of ready
    initial
    begin
        int stall;
        result_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    // Score each result beat mid-cycle, ahead of the edge that takes it
    always @(negedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/owe_pkg.sv
hdl/owe_front.sv
hdl/owe_queue.sv
hdl/owe_back.sv
hdl/override_window_extractor_core.sv
sim/tb_top.sv
